### hdl/cfd_pkg.sv
// shared constants, types and the crc byte update for the frame deframer
package cfd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned MAX_PAYLOAD  = 64;
  localparam int unsigned STORE_DEPTH  = 64;
  localparam int unsigned LEN_W        = 7;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned WIN_IDX_W    = $clog2(HEADER_BYTES);
  localparam int unsigned CRC_W        = 16;
  localparam int unsigned CFG_ADDR_W   = 4;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  typedef logic [1:0] status_t;

  localparam status_t ST_DATA    = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_CRC_ERR = 2'd2;

  // one byte of reflected crc-16, eight shift steps
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/cfd_in_if.sv
// input word channel: one received serial byte per word
interface cfd_in_if;
  logic                         valid;
  logic                         ready;
  logic [cfd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/cfd_out_if.sv
// result word channel: payload bytes or frame status
interface cfd_out_if;
  logic                         valid;
  logic                         ready;
  cfd_pkg::status_t             status;
  logic [cfd_pkg::BYTE_W-1:0]   frame_address;
  logic [cfd_pkg::LEN_W-1:0]    payload_length;
  logic [cfd_pkg::IDX_W-1:0]    payload_index;
  logic [cfd_pkg::BYTE_W-1:0]   payload_byte;
  logic                         last;

  modport source (output valid, output status, output frame_address, output payload_length,
                  output payload_index, output payload_byte, output last, input ready);
  modport sink   (input valid, input status, input frame_address, input payload_length,
                  input payload_index, input payload_byte, input last, output ready);
endinterface

### hdl/crc_checked_frame_deframer.sv
// Frame deframer: finds a six-byte header (two sync bytes, command, address, length,
// 8-bit sum) in the byte stream, buffers the payload in a 64-entry RAM, checks the
// trailing little-endian crc-16/modbus and then plays the payload out of the RAM, or
// gives one status word for an empty or failed frame. Header, payload and crc bytes
// are taken one per cycle while the input is not held. A header match holds the input
// while the crc unit walks the six header bytes one byte per cycle. After the crc bytes
// the input stays held until the last word of the frame has been loaded into the output
// register: one RAM read per cycle into the output register while the sink is ready,
// one read per payload word, or a single status word. Config registers: 0 sync_first,
// 1 sync_second, 2 command_code.
module crc_checked_frame_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  cfd_in_if.sink                           in_ch,
  cfd_out_if.source                        out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cfd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cfd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam logic [2:0] PH_SEARCH  = 3'd0;
  localparam logic [2:0] PH_HDRCRC  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CRC_LO  = 3'd3;
  localparam logic [2:0] PH_CRC_HI  = 3'd4;
  localparam logic [2:0] PH_STATUS  = 3'd5;
  localparam logic [2:0] PH_EMIT    = 3'd6;

  localparam logic [1:0] REG_SYNC_FIRST   = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND  = 2'd1;
  localparam logic [1:0] REG_COMMAND_CODE = 2'd2;

  localparam int unsigned BW = cfd_pkg::BYTE_W;
  localparam int unsigned HB = cfd_pkg::HEADER_BYTES;
  localparam int unsigned WW = cfd_pkg::WIN_IDX_W;
  localparam int unsigned LW = cfd_pkg::LEN_W;
  localparam int unsigned IW = cfd_pkg::IDX_W;
  localparam int unsigned CW = cfd_pkg::CRC_W;

  // config registers
  logic [BW-1:0] sync_first_r, sync_second_r, command_code_r;
  logic          cfg_wr;
  logic [1:0]    cfg_reg;

  // control state
  logic [2:0]         phase_r, phase_nxt;
  logic [BW-1:0]      win_r [HB];
  logic [BW-1:0]      win_nxt [HB];
  logic [WW-1:0]      fill_r, fill_nxt;
  logic [WW-1:0]      hcnt_r, hcnt_nxt;
  logic [BW-1:0]      addr_r, addr_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      crc_r, crc_nxt;
  logic [BW-1:0]      crc_lo_r, crc_lo_nxt;
  cfd_pkg::status_t   stat_r, stat_nxt;

  // output register
  logic               ov_r, ov_nxt;
  cfd_pkg::status_t   o_status_r, o_status_nxt;
  logic [BW-1:0]      o_addr_r, o_addr_nxt;
  logic [LW-1:0]      o_len_r, o_len_nxt;
  logic [IW-1:0]      o_idx_r, o_idx_nxt;
  logic [BW-1:0]      o_byte_r;
  logic               o_last_r, o_last_nxt;

  // payload memory
  logic [BW-1:0]      payload_mem [cfd_pkg::STORE_DEPTH];
  logic               mem_we;
  logic               load_data;
  logic               load_status;

  logic               in_acc;
  logic               out_free;
  logic [BW-1:0]      rx;
  logic [BW-1:0]      w [HB];
  logic [BW-1:0]      hdr_sum;
  logic               hdr_ok;
  logic [LW-1:0]      cnt_inc;

  assign rx       = in_ch.rx_byte;
  assign in_ch.ready = (phase_r == PH_SEARCH) || (phase_r == PH_PAYLOAD) ||
                       (phase_r == PH_CRC_LO) || (phase_r == PH_CRC_HI);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;
  assign cnt_inc  = LW'(cnt_r + 1'b1);

  // window with the incoming byte placed at the fill position
  always_comb begin
    for (int i = 0; i < HB; i++) begin
      w[i] = win_r[i];
    end
    w[fill_r] = rx;
    hdr_sum = w[0] + w[1] + w[2] + w[3] + w[4];
    hdr_ok  = (w[0] == sync_first_r) && (w[1] == sync_second_r) &&
              (w[2] == command_code_r) && (w[5] == hdr_sum) &&
              ({1'b0, w[4]} <= (BW+1)'(cfd_pkg::MAX_PAYLOAD));
  end

  always_comb begin
    phase_nxt    = phase_r;
    for (int i = 0; i < HB; i++) begin
      win_nxt[i] = win_r[i];
    end
    fill_nxt     = fill_r;
    hcnt_nxt     = hcnt_r;
    addr_nxt     = addr_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    stat_nxt     = stat_r;
    o_status_nxt = o_status_r;
    o_addr_nxt   = o_addr_r;
    o_len_nxt    = o_len_r;
    o_idx_nxt    = o_idx_r;
    o_last_nxt   = o_last_r;
    mem_we       = 1'b0;
    load_data    = 1'b0;
    load_status  = 1'b0;

    unique case (phase_r)
      PH_SEARCH: begin
        if (in_acc) begin
          if (fill_r != WW'(HB - 1)) begin
            for (int i = 0; i < HB; i++) begin
              win_nxt[i] = w[i];
            end
            fill_nxt = WW'(fill_r + 1'b1);
          end else if (hdr_ok) begin
            for (int i = 0; i < HB; i++) begin
              win_nxt[i] = w[i];
            end
            fill_nxt  = '0;
            hcnt_nxt  = '0;
            crc_nxt   = cfd_pkg::CRC_INIT;
            addr_nxt  = w[3];
            len_nxt   = w[4][LW-1:0];
            cnt_nxt   = '0;
            phase_nxt = PH_HDRCRC;
          end else begin
            // drop the oldest byte and keep looking
            for (int i = 0; i < HB - 1; i++) begin
              win_nxt[i] = w[i+1];
            end
            win_nxt[HB-1] = w[HB-1];
            fill_nxt = WW'(HB - 1);
          end
        end
      end
      PH_HDRCRC: begin
        crc_nxt  = cfd_pkg::crc_feed(crc_r, win_r[hcnt_r]);
        hcnt_nxt = WW'(hcnt_r + 1'b1);
        if (hcnt_r == WW'(HB - 1)) begin
          phase_nxt = (len_r == '0) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (in_acc) begin
          mem_we  = 1'b1;
          crc_nxt = cfd_pkg::crc_feed(crc_r, rx);
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_CRC_LO;
          end
        end
      end
      PH_CRC_LO: begin
        if (in_acc) begin
          crc_lo_nxt = rx;
          phase_nxt  = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        if (in_acc) begin
          cnt_nxt = '0;
          if ({rx, crc_lo_r} != crc_r) begin
            stat_nxt  = cfd_pkg::ST_CRC_ERR;
            phase_nxt = PH_STATUS;
          end else if (len_r == '0) begin
            stat_nxt  = cfd_pkg::ST_EMPTY;
            phase_nxt = PH_STATUS;
          end else begin
            phase_nxt = PH_EMIT;
          end
        end
      end
      PH_STATUS: begin
        if (out_free) begin
          load_status  = 1'b1;
          o_status_nxt = stat_r;
          o_addr_nxt   = addr_r;
          o_len_nxt    = len_r;
          o_idx_nxt    = '0;
          o_last_nxt   = 1'b1;
          phase_nxt    = PH_SEARCH;
          fill_nxt     = '0;
          cnt_nxt      = '0;
          crc_nxt      = cfd_pkg::CRC_INIT;
        end
      end
      PH_EMIT: begin
        if (out_free) begin
          load_data    = 1'b1;
          o_status_nxt = cfd_pkg::ST_DATA;
          o_addr_nxt   = addr_r;
          o_len_nxt    = len_r;
          o_idx_nxt    = cnt_r[IW-1:0];
          o_last_nxt   = (cnt_inc == len_r);
          cnt_nxt      = cnt_inc;
          if (cnt_inc == len_r) begin
            phase_nxt = PH_SEARCH;
            fill_nxt  = '0;
            cnt_nxt   = '0;
            crc_nxt   = cfd_pkg::CRC_INIT;
          end
        end
      end
      default: begin
        phase_nxt = PH_SEARCH;
      end
    endcase

    if (load_data || load_status) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      for (int i = 0; i < HB; i++) begin
        win_r[i] <= '0;
      end
      fill_r   <= '0;
      hcnt_r   <= '0;
      addr_r   <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= cfd_pkg::CRC_INIT;
      crc_lo_r <= '0;
      stat_r   <= cfd_pkg::ST_DATA;
      ov_r     <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      for (int i = 0; i < HB; i++) begin
        win_r[i] <= win_nxt[i];
      end
      fill_r   <= fill_nxt;
      hcnt_r   <= hcnt_nxt;
      addr_r   <= addr_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      stat_r   <= stat_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_status_r <= o_status_nxt;
    o_addr_r   <= o_addr_nxt;
    o_len_r    <= o_len_nxt;
    o_idx_r    <= o_idx_nxt;
    o_last_r   <= o_last_nxt;
  end

  // payload ram: write while collecting, registered read straight into the output word
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem[cnt_r[IW-1:0]] <= rx;
    end
    if (load_data) begin
      o_byte_r <= payload_mem[cnt_r[IW-1:0]];
    end else if (load_status) begin
      o_byte_r <= '0;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.status         = o_status_r;
  assign out_ch.frame_address  = o_addr_r;
  assign out_ch.payload_length = o_len_r;
  assign out_ch.payload_index  = o_idx_r;
  assign out_ch.payload_byte   = o_byte_r;
  assign out_ch.last           = o_last_r;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_reg = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r   <= 8'hAA;
      sync_second_r  <= 8'h55;
      command_code_r <= 8'h00;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_SYNC_FIRST:   sync_first_r   <= pwdata[BW-1:0];
        REG_SYNC_SECOND:  sync_second_r  <= pwdata[BW-1:0];
        REG_COMMAND_CODE: command_code_r <= pwdata[BW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_SYNC_FIRST:   prdata = cfd_pkg::CFG_DATA_W'(sync_first_r);
      REG_SYNC_SECOND:  prdata = cfd_pkg::CFG_DATA_W'(sync_second_r);
      REG_COMMAND_CODE: prdata = cfd_pkg::CFG_DATA_W'(command_code_r);
      default:          prdata = '0;
    endcase
  end

endmodule
